[hw/rtl/acpu_pkg.sv]
// Shared constants, codes and payload types of the accumulator CPU core.
package acpu_pkg;

    localparam int WORD_BITS      = 8;
    localparam int PROG_DEPTH     = 256;
    localparam int PROG_ADDR_BITS = $clog2(PROG_DEPTH);
    localparam int PC_BITS        = PROG_ADDR_BITS + 1;
    localparam int DATA_DEPTH     = 16;
    localparam int DATA_ADDR_BITS = $clog2(DATA_DEPTH);

    typedef enum logic [1:0] {
        OPN_WRITE = 2'd0,
        OPN_START = 2'd1,
        OPN_TICK  = 2'd2
    } operation_t;

    typedef enum logic [3:0] {
        OP_HLT = 4'd0,
        OP_ADD = 4'd1,
        OP_SUB = 4'd2,
        OP_STO = 4'd3,
        OP_LD  = 4'd4,
        OP_B   = 4'd5,
        OP_BZ  = 4'd6,
        OP_LDV = 4'd7,
        OP_INP = 4'd8,
        OP_OUT = 4'd9,
        OP_AND = 4'd10,
        OP_OR  = 4'd11,
        OP_NOT = 4'd12
    } opcode_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] prog_address;
        logic [7:0] prog_word;
        logic [7:0] input_value;
    } cmd_t;

    typedef struct packed {
        logic [7:0] accumulator_value;
        logic [7:0] output_port;
        logic [3:0] executed_opcode;
        logic       executed;
        logic       running;
    } rsp_t;

    // Architectural registers of the machine.
    typedef struct packed {
        logic [PC_BITS-1:0]   pc;
        logic [WORD_BITS-1:0] acc;
        logic [WORD_BITS-1:0] outr;
        logic                 run;
    } cpu_state_t;

    // Data memory write request from the execute logic.
    typedef struct packed {
        logic                      en;
        logic [DATA_ADDR_BITS-1:0] addr;
        logic [WORD_BITS-1:0]      data;
    } dmem_wr_t;

endpackage

[hw/rtl/acpu_prog_ram.sv]
// Program store: one write port, one registered read port with write-first bypass.
module acpu_prog_ram #(
    parameter int DEPTH     = 256,
    parameter int WIDTH     = 8,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // A write to the address being read returns the new word.
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/acpu_exec.sv]
// Execute logic: next machine state and result beat for one command.
module acpu_exec import acpu_pkg::*; (
    input  cmd_t                 cmd,
    input  cpu_state_t           cur,
    input  logic [WORD_BITS-1:0] instr,
    input  logic [WORD_BITS-1:0] dmem_rdata,
    output cpu_state_t           nxt,
    output dmem_wr_t             dmem_wr,
    output rsp_t                 rsp
);

    opcode_t                   opcode;
    logic [3:0]                operand;
    logic [3:0]                exec_op;
    logic                      executed;

    assign opcode  = opcode_t'(instr[7:4]);
    assign operand = instr[3:0];

    always_comb
    begin
        nxt      = cur;
        dmem_wr  = '0;
        exec_op  = OP_HLT;
        executed = 1'b0;
        unique case (operation_t'(cmd.operation))
            OPN_WRITE:
            begin
                // Program store write is handled at the RAM port.
            end
            OPN_START:
            begin
                nxt.pc  = '0;
                nxt.run = 1'b1;
            end
            OPN_TICK:
            begin
                if (cur.run)
                begin
                    if (cur.pc >= PC_BITS'(PROG_DEPTH))
                    begin
                        // Ran off the end of the program store.
                        nxt.run = 1'b0;
                    end
                    else
                    begin
                        executed = 1'b1;
                        exec_op  = opcode;
                        nxt.pc   = cur.pc + PC_BITS'(1);
                        unique case (opcode)
                            OP_HLT: nxt.run = 1'b0;
                            OP_ADD: nxt.acc = cur.acc + dmem_rdata;
                            OP_SUB: nxt.acc = cur.acc - dmem_rdata;
                            OP_STO:
                            begin
                                dmem_wr.en   = 1'b1;
                                dmem_wr.addr = operand;
                                dmem_wr.data = cur.acc;
                            end
                            OP_LD:  nxt.acc = dmem_rdata;
                            OP_B:   nxt.pc  = PC_BITS'(operand);
                            OP_BZ:
                            begin
                                if (cur.acc == '0)
                                begin
                                    nxt.pc = PC_BITS'(operand);
                                end
                            end
                            OP_LDV: nxt.acc = WORD_BITS'(operand);
                            OP_INP: nxt.acc = cmd.input_value;
                            OP_OUT: nxt.outr = cur.acc;
                            OP_AND: nxt.acc = cur.acc & dmem_rdata;
                            OP_OR:  nxt.acc = cur.acc | dmem_rdata;
                            OP_NOT: nxt.acc = ~cur.acc;
                            default:
                            begin
                                // The three top opcodes do nothing.
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                // Unused operation code leaves the state alone.
            end
        endcase
    end

    always_comb
    begin
        rsp.accumulator_value = nxt.acc;
        rsp.output_port       = nxt.outr;
        rsp.executed_opcode   = exec_op;
        rsp.executed          = executed;
        rsp.running           = nxt.run;
    end

endmodule

[hw/rtl/accumulator_cpu_8bit_core.sv]
// A command beat waits in the command register, then executes into the result register.
// Throughput: one command beat per cycle while responses are taken; the execute path is
// one pass through the decoder and ALU, and the program word is prefetched from the program
// store at the next program counter so its registered read never stalls a tick.
// Reset clears the program counter, accumulator, output register, run flag and
// data memory at once; the program store is not cleared and holds garbage until written.
module accumulator_cpu_8bit_core import acpu_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // Command register stage.
    logic                 cmd_valid_reg;
    cmd_t                 cmd_reg;

    // Architectural state.
    cpu_state_t           state_reg;
    cpu_state_t           state_next;
    logic [WORD_BITS-1:0] dmem_reg [DATA_DEPTH];

    // Result register stage.
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;

    logic                 fire;
    logic [WORD_BITS-1:0] instr;
    logic [WORD_BITS-1:0] dmem_rdata;
    dmem_wr_t             dmem_wr;
    logic                 prog_we;
    logic [PC_BITS-1:0]   fetch_pc;

    // The held command executes when the result register is free or being emptied.
    assign fire      = cmd_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign cmd_ready = !cmd_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            cmd_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd;
        end
    end

    // Program writes beyond the store depth are dropped.
    assign prog_we = fire && (operation_t'(cmd_reg.operation) == OPN_WRITE)
                     && (PC_BITS'(cmd_reg.prog_address) < PC_BITS'(PROG_DEPTH));

    // The store is read every cycle at the program counter that will hold after
    // this edge, so the instruction for the next tick is always ready. The RAM
    // bypass keeps that word current when a write hits the same address.
    assign fetch_pc = fire ? state_next.pc : state_reg.pc;

    acpu_prog_ram #(
        .DEPTH (PROG_DEPTH),
        .WIDTH (WORD_BITS)
    ) u_prog_ram (
        .clk   (clk),
        .we    (prog_we),
        .waddr (cmd_reg.prog_address[PROG_ADDR_BITS-1:0]),
        .wdata (cmd_reg.prog_word),
        .raddr (fetch_pc[PROG_ADDR_BITS-1:0]),
        .rdata (instr)
    );

    // The operand nibble addresses the data memory directly.
    assign dmem_rdata = dmem_reg[instr[DATA_ADDR_BITS-1:0]];

    acpu_exec u_exec (
        .cmd        (cmd_reg),
        .cur        (state_reg),
        .instr      (instr),
        .dmem_rdata (dmem_rdata),
        .nxt        (state_next),
        .dmem_wr    (dmem_wr),
        .rsp        (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            for (int i = 0; i < DATA_DEPTH; i++)
            begin
                dmem_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            state_reg <= state_next;
            if (dmem_wr.en)
            begin
                dmem_reg[dmem_wr.addr] <= dmem_wr.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A start beat leaves the machine running from address zero.
    a_start_resets_pc: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (operation_t'(cmd_reg.operation) == OPN_START)
        |=> (state_reg.pc == '0) && state_reg.run)
        else $error("start beat did not restart the program counter");

    // Nothing executes while the machine is halted, and only a start beat wakes it.
    a_halted_no_exec: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !state_reg.run && (operation_t'(cmd_reg.operation) != OPN_START)
        |=> !rsp_reg.executed && !state_reg.run)
        else $error("instruction executed while halted");

    // The program counter never goes more than one past the last program address.
    a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pc <= PC_BITS'(PROG_DEPTH))
        else $error("program counter out of range");

endmodule

[sim/tb_accumulator_cpu_8bit_core.sv]
// Self-checking testbench for the accumulator CPU core: predicted machine state per beat.
`timescale 1ns / 1ps

module tb_accumulator_cpu_8bit_core;
    import acpu_pkg::*;

    // Operation code 3 is not used by the core; it must report state and change nothing.
    localparam logic [1:0] OPN_UNUSED = 2'd3;

    // Cycles allowed after the last expected response.
    localparam int SETTLE_CYCLES = 6;

    // Useful command beats in the random part of the run.
    localparam int RANDOM_BEATS = 850;

    // Random beats after which the whole program store is filled and run off the end.
    localparam int RUN_OFF_AFTER = 150;

    logic clk;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // Mirror of the machine. Each accepted command beat is applied to a private copy
    // of the architectural state, and the state it leaves behind is queued as the
    // response that the core must return for that beat.
    class cpu_mirror;
        logic [WORD_BITS-1:0] prog [PROG_DEPTH];
        bit                   written [PROG_DEPTH];
        logic [WORD_BITS-1:0] dmem [DATA_DEPTH];
        logic [PC_BITS-1:0]   pc;
        logic [WORD_BITS-1:0] acc;
        logic [WORD_BITS-1:0] outr;
        bit                   run;
        rsp_t                 state_after_cmd [$];
        int                   mismatches;

        function new();
            foreach (dmem[i])
            begin
                dmem[i] = '0;
            end
            foreach (written[i])
            begin
                written[i] = 1'b0;
            end
            pc         = '0;
            acc        = '0;
            outr       = '0;
            run        = 1'b0;
            mismatches = 0;
        endfunction

        function void apply_command(cmd_t c);
            logic [WORD_BITS-1:0] instr;
            logic [3:0]           opc;
            logic [3:0]           opr;
            logic [PC_BITS-1:0]   next_pc;
            rsp_t                 r;

            r = '0;
            case (c.operation)
                OPN_WRITE:
                begin
                    prog[c.prog_address]    = c.prog_word;
                    written[c.prog_address] = 1'b1;
                end
                OPN_START:
                begin
                    pc  = '0;
                    run = 1'b1;
                end
                OPN_TICK:
                begin
                    if (run)
                    begin
                        if (pc >= PC_BITS'(PROG_DEPTH))
                        begin
                            // Ran past the last address: halt without executing.
                            run = 1'b0;
                        end
                        else
                        begin
                            instr   = prog[pc[PROG_ADDR_BITS-1:0]];
                            opc     = instr[7:4];
                            opr     = instr[3:0];
                            next_pc = pc + PC_BITS'(1);
                            r.executed        = 1'b1;
                            r.executed_opcode = opc;
                            case (opc)
                                OP_HLT: run = 1'b0;
                                OP_ADD: acc = acc + dmem[opr];
                                OP_SUB: acc = acc - dmem[opr];
                                OP_STO: dmem[opr] = acc;
                                OP_LD:  acc = dmem[opr];
                                OP_B:   next_pc = PC_BITS'(opr);
                                OP_BZ:
                                begin
                                    if (acc == '0)
                                    begin
                                        next_pc = PC_BITS'(opr);
                                    end
                                end
                                OP_LDV: acc = WORD_BITS'(opr);
                                OP_INP: acc = c.input_value;
                                OP_OUT: outr = acc;
                                OP_AND: acc = acc & dmem[opr];
                                OP_OR:  acc = acc | dmem[opr];
                                OP_NOT: acc = ~acc;
                                default: ;
                            endcase
                            pc = next_pc;
                        end
                    end
                end
                default: ;
            endcase
            r.accumulator_value = acc;
            r.output_port       = outr;
            r.running           = run;
            state_after_cmd.push_back(r);
        endfunction

        task flag_mismatch(string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
            begin
                flag_mismatch($sformatf("%s is %h, predicted %h", name, got, want));
            end
        endtask

        task compare_status(rsp_t r);
            rsp_t want;
            if (state_after_cmd.size() == 0)
            begin
                flag_mismatch("response beat with no command beat waiting for it");
                return;
            end
            want = state_after_cmd.pop_front();
            check_field("accumulator_value", r.accumulator_value, want.accumulator_value);
            check_field("output_port", r.output_port, want.output_port);
            check_field("executed_opcode", 8'(r.executed_opcode), 8'(want.executed_opcode));
            check_field("executed", 8'(r.executed), 8'(want.executed));
            check_field("running", 8'(r.running), 8'(want.running));
        endtask
    endclass

    cpu_mirror mirror;

    // Count of command beats that actually do something (not ignored by the core).
    int useful_beats = 0;
    // While set, neither side idles; the run-off-the-end phase runs this way.
    bit quiet = 1'b0;
    // While set, the response side holds ready low to back the core up.
    bit hold_rsp = 1'b0;

    accumulator_cpu_8bit_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic cmd_t make_cmd(logic [1:0] op, logic [7:0] addr, logic [7:0] word,
                                      logic [7:0] inval);
        cmd_t c;
        c.operation    = op;
        c.prog_address = addr;
        c.prog_word    = word;
        c.input_value  = inval;
        return c;
    endfunction

    // A random instruction word. A straight-line word has no halt and no branch, so a
    // store full of them runs all the way to the end. Otherwise halts are thinned out
    // so that programs live long enough to do something.
    function automatic logic [7:0] random_instr(bit straight);
        logic [3:0] opc;
        opc = 4'($urandom_range(0, 15));
        while ((straight && (opc == OP_HLT || opc == OP_B || opc == OP_BZ)) ||
               (!straight && opc == OP_HLT && $urandom_range(0, 2) != 0))
        begin
            opc = 4'($urandom_range(0, 15));
        end
        return {opc, 4'($urandom_range(0, 15))};
    endfunction

    // Offer one command beat and wait for it to be accepted. Inputs change only on the
    // falling edge; ready is sampled at the rising edge. Valid is only lowered on an
    // idle cycle, never in the same step in which it is raised for the next beat.
    task automatic send_cmd(cmd_t c);
        while (!quiet && $urandom_range(0, 99) < 11)
        begin
            @(negedge clk);
            cmd_valid = 1'b0;
        end
        @(negedge clk);
        cmd       = c;
        cmd_valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (cmd_ready !== 1'b1);
        if (c.operation != OPN_UNUSED && !(c.operation == OPN_TICK && !mirror.run))
        begin
            useful_beats++;
        end
        mirror.apply_command(c);
    endtask

    task automatic write_word(logic [7:0] addr, logic [7:0] word);
        send_cmd(make_cmd(OPN_WRITE, addr, word, 8'($urandom_range(0, 255))));
    endtask

    task automatic start_program();
        send_cmd(make_cmd(OPN_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255))));
    endtask

    // Deliver one clock tick. The program store holds garbage until written, so if the
    // next fetch would land on a word that was never written, that word is written first.
    task automatic tick_once(logic [7:0] inval);
        if (mirror.run && mirror.pc < PC_BITS'(PROG_DEPTH) &&
            !mirror.written[mirror.pc[PROG_ADDR_BITS-1:0]])
        begin
            write_word(mirror.pc[PROG_ADDR_BITS-1:0], random_instr(1'b0));
        end
        send_cmd(make_cmd(OPN_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          inval));
    endtask

    // Response side. Ready is set on the falling edge and a response beat is taken at
    // the rising edge when valid and ready are both high.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rsp_ready = !hold_rsp && (quiet || $urandom_range(0, 99) >= 11);
            @(posedge clk);
            if (rsp_valid === 1'b1 && rsp_ready)
            begin
                mirror.compare_status(rsp);
            end
        end
    end

    // Back-pressure: once the random traffic is under way, the response side refuses
    // beats for a long stretch while commands keep coming, so the core fills up and
    // has to drop cmd_ready.
    initial
    begin
        wait (useful_beats >= 120);
        @(posedge clk);
        hold_rsp = 1'b1;
        repeat (80) @(posedge clk);
        hold_rsp = 1'b0;
    end

    // Hard limit on the run; far above the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int  start_beats;
        int  len;
        int  nticks;
        int  pick;
        bit  ran_off;

        mirror  = new();
        ran_off = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. The program below walks through the arithmetic wrap cases
        // (255 + 15 and 14 - 15), the complement, a taken and an untaken branch on
        // zero, and an unconditional branch, ending on a halt. Addresses 7 and 12 are
        // branched over and deliberately left unwritten.
        write_word(8'd0,  {OP_LDV, 4'hF});
        write_word(8'd1,  {OP_STO, 4'h0});
        write_word(8'd2,  {OP_INP, 4'h0});
        write_word(8'd3,  {OP_ADD, 4'h0});
        write_word(8'd4,  {OP_SUB, 4'h0});
        write_word(8'd5,  {OP_NOT, 4'h0});
        write_word(8'd6,  {OP_BZ,  4'd8});
        write_word(8'd8,  {OP_OUT, 4'h0});
        write_word(8'd9,  {OP_OR,  4'h0});
        write_word(8'd10, {OP_BZ,  4'h0});
        write_word(8'd11, {OP_B,   4'd13});
        write_word(8'd13, {OP_HLT, 4'h0});

        // A tick before any start, and the unused operation code, must change nothing.
        tick_once(8'hFF);
        send_cmd(make_cmd(OPN_UNUSED, 8'hFF, 8'hFF, 8'hFF));

        start_program();
        repeat (12) tick_once(8'hFF);
        // Tick after the halt.
        tick_once(8'h00);

        // Random part: short random programs at the bottom of the store, each started
        // and ticked for a while, with stray writes (also to the running program),
        // restarts and unused codes mixed in.
        start_beats = useful_beats;
        while (useful_beats < start_beats + RANDOM_BEATS)
        begin
            len = ($urandom_range(0, 9) == 0) ? 16 : $urandom_range(1, 12);
            for (int a = 0; a < len; a++)
            begin
                write_word(8'(a), random_instr(1'b0));
            end
            start_program();
            nticks = $urandom_range(4, 48);
            repeat (nticks)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                begin
                    write_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
                else if (pick < 8)
                begin
                    send_cmd(make_cmd(OPN_UNUSED, 8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255))));
                end
                else if (pick < 10)
                begin
                    start_program();
                end
                else
                begin
                    tick_once(8'($urandom_range(0, 255)));
                end
            end

            // Once, fill the whole store with straight-line code and run it until the
            // program counter passes the last address and the machine halts itself.
            // This stretch runs with no idling on either side.
            if (!ran_off && useful_beats >= start_beats + RUN_OFF_AFTER)
            begin
                quiet = 1'b1;
                for (int a = 0; a < PROG_DEPTH; a++)
                begin
                    write_word(8'(a), random_instr(1'b1));
                end
                start_program();
                while (mirror.run)
                begin
                    tick_once(8'($urandom_range(0, 255)));
                end
                quiet   = 1'b0;
                ran_off = 1'b1;
            end
        end

        @(negedge clk);
        cmd_valid = 1'b0;

        // Drain: wait for every predicted response, then keep watching the response side so that
        // any extra response beat would still be caught.
        while (mirror.state_after_cmd.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mirror.mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/acpu_pkg.sv
hw/rtl/acpu_prog_ram.sv
hw/rtl/acpu_exec.sv
hw/rtl/accumulator_cpu_8bit_core.sv
sim/tb_accumulator_cpu_8bit_core.sv
